// ----- rtl/core/pchc_pkg.sv -----
// ----------------------------------------------------------------------------
// pchc_pkg
// Shared constants, types and helpers of the plate color histogram classifier.
// ----------------------------------------------------------------------------
package pchc_pkg;

    localparam int COUNT_BITS     = 24;
    localparam int NUM_CLASSES    = 6;
    localparam int NUM_CHROMA     = 3;
    localparam int BOX_BITS       = 48;
    localparam int CHAN_BITS      = 8;
    localparam int SUM_BITS       = 32;
    localparam int CLASS_BITS     = 3;
    localparam int COLOR_BITS     = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PART_BITS      = COUNT_BITS + 2;
    localparam int TOTAL_BITS     = COUNT_BITS + 3;
    localparam int CMP_BITS       = (COUNT_BITS + 7 > SUM_BITS) ? COUNT_BITS + 7 : SUM_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

    // Byte lanes inside a box register
    localparam int BYTE_LOW_H  = 0;
    localparam int BYTE_LOW_S  = 1;
    localparam int BYTE_LOW_V  = 2;
    localparam int BYTE_HIGH_H = 3;
    localparam int BYTE_HIGH_S = 4;
    localparam int BYTE_HIGH_V = 5;

    typedef logic [BOX_BITS-1:0]   t_box;
    typedef logic [CLASS_BITS-1:0] t_class;
    typedef logic [COLOR_BITS-1:0] t_color;

    localparam t_class CLS_BLUE  = 3'd0;
    localparam t_class CLS_WHITE = 3'd3;
    localparam t_class CLS_BLACK = 3'd5;

    localparam t_color COLOR_WHITE = 3'd3;
    localparam t_color COLOR_BLACK = 3'd4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LAST_INDEX = 3'd5;

    // Reset boxes, black first so that index 0 is blue
    localparam logic [NUM_CLASSES-1:0][BOX_BITS-1:0] BOX_RESET = {
        48'h960AB4000000,
        48'hDD2BB4960000,
        48'hFF1EB4DD0000,
        48'hFFFF4B141E2C,
        48'hFFFF2B141E08,
        48'hFFFF96141E55
    };

    typedef struct packed {
        logic                   valid;
        logic [NUM_CLASSES-1:0] hit;
        logic [CHAN_BITS-1:0]   brightness;
        logic                   last;
    } t_cls;

    typedef struct packed {
        logic                                   valid;
        logic [NUM_CLASSES-1:0][COUNT_BITS-1:0] counts;
        logic [COUNT_BITS-1:0]                  total;
        logic [SUM_BITS-1:0]                    bsum;
        logic                                   sat;
    } t_snap;

    function automatic logic [CHAN_BITS-1:0] box_byte(input t_box box, input int k);
        box_byte = box[CHAN_BITS*k +: CHAN_BITS];
    endfunction

    function automatic logic in_box(input t_box box,
                                    input logic [CHAN_BITS-1:0] h,
                                    input logic [CHAN_BITS-1:0] s,
                                    input logic [CHAN_BITS-1:0] v);
        in_box = (h >= box_byte(box, BYTE_LOW_H)) && (h <= box_byte(box, BYTE_HIGH_H)) &&
                 (s >= box_byte(box, BYTE_LOW_S)) && (s <= box_byte(box, BYTE_HIGH_S)) &&
                 (v >= box_byte(box, BYTE_LOW_V)) && (v <= box_byte(box, BYTE_HIGH_V));
    endfunction

endpackage

// ----- rtl/core/pchc_classify.sv -----
// ----------------------------------------------------------------------------
// pchc_classify
// Box registers, pixel input register and first-match box classification.
// ----------------------------------------------------------------------------
module pchc_classify
    import pchc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_in_valid,
    input  logic [CHAN_BITS-1:0]      i_hue,
    input  logic [CHAN_BITS-1:0]      i_saturation,
    input  logic [CHAN_BITS-1:0]      i_brightness,
    input  logic                      i_last_pixel,
    input  logic                      i_cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [BOX_BITS-1:0]       i_cfg_data,
    output t_cls                      o_cls
);

    t_box [NUM_CLASSES-1:0] r_box;

    logic                 r_in_valid;
    logic [CHAN_BITS-1:0] r_hue;
    logic [CHAN_BITS-1:0] r_sat;
    logic [CHAN_BITS-1:0] r_bri;
    logic                 r_last;

    t_cls                   r_cls;
    logic [NUM_CLASSES-1:0] n_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= BOX_RESET;
        end else if (i_cfg_valid && (i_cfg_index <= CFG_LAST_INDEX)) begin
            r_box[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_adv) begin
            r_in_valid <= i_in_valid;
        end
        if (i_adv && i_in_valid) begin
            r_hue  <= i_hue;
            r_sat  <= i_saturation;
            r_bri  <= i_brightness;
            r_last <= i_last_pixel;
        end
    end

    // First box that contains the pixel wins
    always_comb begin
        logic found;
        found = 1'b0;
        n_hit = '0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (!found && in_box(r_box[k], r_hue, r_sat, r_bri)) begin
                n_hit[k] = 1'b1;
                found    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls.valid <= 1'b0;
        end else if (i_adv) begin
            r_cls.valid <= r_in_valid;
        end
        if (i_adv && r_in_valid) begin
            r_cls.hit        <= n_hit;
            r_cls.brightness <= r_bri;
            r_cls.last       <= r_last;
        end
    end

    assign o_cls = r_cls;

endmodule

// ----- rtl/core/pchc_accum.sv -----
// ----------------------------------------------------------------------------
// pchc_accum
// Per-image class counters, pixel count and brightness sum, all saturating.
// ----------------------------------------------------------------------------
module pchc_accum
    import pchc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  t_cls  i_cls,
    output t_snap o_snap
);

    logic [NUM_CLASSES-1:0][COUNT_BITS-1:0] r_counts;
    logic [COUNT_BITS-1:0]                  r_total;
    logic [SUM_BITS-1:0]                    r_bsum;
    logic                                   r_sat;

    logic [NUM_CLASSES-1:0][COUNT_BITS-1:0] n_counts;
    logic [COUNT_BITS-1:0]                  n_total;
    logic [SUM_BITS-1:0]                    n_bsum;
    logic                                   n_sat;
    logic [SUM_BITS:0]                      sum_ext;

    t_snap r_snap;

    always_comb begin
        n_counts = r_counts;
        n_total  = r_total;
        n_sat    = r_sat;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (i_cls.hit[k]) begin
                if (r_counts[k] == COUNT_MAX) begin
                    n_sat = 1'b1;
                end else begin
                    n_counts[k] = r_counts[k] + 1'b1;
                end
            end
        end
        if (r_total == COUNT_MAX) begin
            n_sat = 1'b1;
        end else begin
            n_total = r_total + 1'b1;
        end
        sum_ext = {1'b0, r_bsum} + (SUM_BITS+1)'(i_cls.brightness);
        if (sum_ext[SUM_BITS]) begin
            n_bsum = SUM_MAX;
            n_sat  = 1'b1;
        end else begin
            n_bsum = sum_ext[SUM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts     <= '0;
            r_total      <= '0;
            r_bsum       <= '0;
            r_sat        <= 1'b0;
            r_snap.valid <= 1'b0;
        end else if (i_adv) begin
            r_snap.valid <= i_cls.valid && i_cls.last;
            if (i_cls.valid) begin
                if (i_cls.last) begin
                    // hand the finished image to the decision, start a fresh one
                    r_snap.counts <= n_counts;
                    r_snap.total  <= n_total;
                    r_snap.bsum   <= n_bsum;
                    r_snap.sat    <= n_sat;
                    r_counts      <= '0;
                    r_total       <= '0;
                    r_bsum        <= '0;
                    r_sat         <= 1'b0;
                end else begin
                    r_counts <= n_counts;
                    r_total  <= n_total;
                    r_bsum   <= n_bsum;
                    r_sat    <= n_sat;
                end
            end
        end
    end

    assign o_snap = r_snap;

endmodule

// ----- rtl/core/pchc_decide.sv -----
// ----------------------------------------------------------------------------
// pchc_decide
// Two-stage color decision over a finished image and the result register.
// ----------------------------------------------------------------------------
module pchc_decide
    import pchc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  t_snap  i_snap,
    output logic   o_out_valid,
    output t_color o_plate_color,
    output logic   o_count_saturated
);

    localparam logic [TOTAL_BITS-1:0] SHARE_DIV = TOTAL_BITS'(6);

    t_class                n_win;
    t_class                n_chrom;
    logic [PART_BITS-1:0]  n_sum_a;
    logic [PART_BITS-1:0]  n_sum_b;
    logic                  n_gray_white;

    logic                  r_d_valid;
    t_class                r_win;
    t_class                r_chrom;
    logic [COUNT_BITS-1:0] r_chrom_cnt;
    logic [PART_BITS-1:0]  r_sum_a;
    logic [PART_BITS-1:0]  r_sum_b;
    logic                  r_gray_white;
    logic                  r_sat;

    logic [TOTAL_BITS-1:0] total;
    logic [TOTAL_BITS-1:0] bound;
    t_color                n_color;

    logic                  r_out_valid;
    t_color                r_color;
    logic                  r_out_sat;

    // Argmax with strict compare: lower index keeps a tie
    always_comb begin
        n_win   = CLS_BLUE;
        n_chrom = CLS_BLUE;
        for (int k = 1; k < NUM_CLASSES; k++) begin
            if (i_snap.counts[k] > i_snap.counts[n_win]) begin
                n_win = t_class'(k);
            end
        end
        for (int k = 1; k < NUM_CHROMA; k++) begin
            if (i_snap.counts[k] > i_snap.counts[n_chrom]) begin
                n_chrom = t_class'(k);
            end
        end
        n_sum_a = PART_BITS'(i_snap.counts[0]) + PART_BITS'(i_snap.counts[1]) +
                  PART_BITS'(i_snap.counts[2]);
        n_sum_b = PART_BITS'(i_snap.counts[3]) + PART_BITS'(i_snap.counts[4]) +
                  PART_BITS'(i_snap.counts[5]);
        n_gray_white = CMP_BITS'(i_snap.bsum) > (CMP_BITS'(i_snap.total) << 7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_adv) begin
            r_d_valid <= i_snap.valid;
        end
        if (i_adv && i_snap.valid) begin
            r_win        <= n_win;
            r_chrom      <= n_chrom;
            r_chrom_cnt  <= i_snap.counts[n_chrom];
            r_sum_a      <= n_sum_a;
            r_sum_b      <= n_sum_b;
            r_gray_white <= n_gray_white;
            r_sat        <= i_snap.sat;
        end
    end

    // count >= floor(total/6) is the same as total < 6*count + 6
    always_comb begin
        total = TOTAL_BITS'(r_sum_a) + TOTAL_BITS'(r_sum_b);
        bound = (TOTAL_BITS'(r_chrom_cnt) << 2) + (TOTAL_BITS'(r_chrom_cnt) << 1) + SHARE_DIV;
        if (r_win < CLS_WHITE) begin
            n_color = t_color'(r_win);
        end else if (total < bound) begin
            n_color = t_color'(r_chrom);
        end else if (r_win == CLS_WHITE) begin
            n_color = COLOR_WHITE;
        end else if (r_win == CLS_BLACK) begin
            n_color = COLOR_BLACK;
        end else begin
            n_color = r_gray_white ? COLOR_WHITE : COLOR_BLACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= r_d_valid;
        end
        if (i_adv && r_d_valid) begin
            r_color   <= n_color;
            r_out_sat <= r_sat;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_plate_color     = r_color;
    assign o_count_saturated = r_out_sat;

endmodule

// ----- rtl/core/plate_color_histogram_classifier_top.sv -----
// ----------------------------------------------------------------------------
// plate_color_histogram_classifier_top
// Classifies HSV pixels into color boxes and picks one plate color per image.
//
//   channel   handshake                   payload
//   pixel in  i_in_valid / o_in_ready     i_hue, i_saturation, i_brightness,
//                                         i_last_pixel
//   color out o_out_valid / i_out_ready   o_plate_color, o_count_saturated
//   config    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One pixel item per cycle while the output is not stalled; a color item
// leaves once the last pixel of its image has passed the input register and
// the class, count, decision and result registers that follow it.
// The whole pipeline holds while a color waits at the output and i_out_ready
// is low; o_in_ready follows that stall. Config writes are taken every cycle.
// Reset restores the default boxes and clears all counters; no sweep needed.
// ----------------------------------------------------------------------------
module plate_color_histogram_classifier_top
    import pchc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [CHAN_BITS-1:0]      i_hue,
    input  logic [CHAN_BITS-1:0]      i_saturation,
    input  logic [CHAN_BITS-1:0]      i_brightness,
    input  logic                      i_last_pixel,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [COLOR_BITS-1:0]     o_plate_color,
    output logic                      o_count_saturated,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [BOX_BITS-1:0]       i_cfg_data
);

    logic  w_adv;
    logic  w_out_valid;
    t_cls  w_cls;
    t_snap w_snap;

    // Advance everything unless a finished color is stuck at the output
    assign w_adv       = !w_out_valid || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = w_out_valid;

    pchc_classify u_classify (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_in_valid   (i_in_valid),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .i_last_pixel (i_last_pixel),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cls        (w_cls)
    );

    pchc_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cls   (w_cls),
        .o_snap  (w_snap)
    );

    pchc_decide u_decide (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_adv             (w_adv),
        .i_snap            (w_snap),
        .o_out_valid       (w_out_valid),
        .o_plate_color     (o_plate_color),
        .o_count_saturated (o_count_saturated)
    );

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the plate color histogram classifier. Streams pixel
// images through the valid/ready pixel port under several box settings.
// Random sender gaps and receiver stalls are applied, plus one long output
// hold-off. Every plate color is checked against an in-bench histogram
// predictor.
// ----------------------------------------------------------------------------
module tb;
    import pchc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int GRAY_SPLIT_V   = 128;
    localparam int MAX_REPORTS    = 10;
    localparam int MIN_IMAGES     = 48;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_BOX   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_YELLOW_BOX = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_BOX  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WHITE_BOX  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRAY_BOX   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLACK_BOX  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PAST_END   = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_INDEX  = 3'd7;

    localparam t_class CLS_GRAY  = 3'd4;
    localparam int     TGT_NOISE = NUM_CLASSES;

    typedef enum int {MIX_ANY, MIX_NEUTRAL, MIX_GRAY} mix_e;

    typedef struct packed {
        logic [CHAN_BITS-1:0] hue;
        logic [CHAN_BITS-1:0] sat;
        logic [CHAN_BITS-1:0] val;
        logic                 last;
    } pixel_t;

    typedef struct packed {
        t_color color;
        logic   sat;
    } plate_result_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [CHAN_BITS-1:0]      i_hue = '0;
    logic [CHAN_BITS-1:0]      i_saturation = '0;
    logic [CHAN_BITS-1:0]      i_brightness = '0;
    logic                      i_last_pixel = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [COLOR_BITS-1:0]     o_plate_color;
    logic                      o_count_saturated;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [BOX_BITS-1:0]       i_cfg_data = '0;

    // predictor state
    t_box                  box_cfg [NUM_CLASSES];
    logic [COUNT_BITS-1:0] class_cnt [NUM_CLASSES];
    logic [COUNT_BITS-1:0] pixel_cnt = '0;
    logic [SUM_BITS-1:0]   vsum = '0;
    logic                  sat_seen = 1'b0;

    pixel_t        pixel_q [$];
    plate_result_t plate_expect_q [$];
    plate_result_t want;
    pixel_t        next_px;

    logic px_acc = 1'b0;
    logic cfg_acc = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   rx_cycle = 0;
    int   holdoff_left = 0;
    logic holdoff_arm = 1'b0;
    logic holdoff_done = 1'b0;

    int idle_cycles = 0;
    int err_count = 0;
    int pixels_fed = 0;
    int images_done = 0;
    int images_queued = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int settings_run = 0;
    int in_held = 0;
    int color_tally [8];

    plate_color_histogram_classifier_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_hue             (i_hue),
        .i_saturation      (i_saturation),
        .i_brightness      (i_brightness),
        .i_last_pixel      (i_last_pixel),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_plate_color     (o_plate_color),
        .o_count_saturated (o_count_saturated),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_box pack_box(input int lh, input int ls, input int lv,
                                      input int hh, input int hs, input int hv);
        return {8'(hv), 8'(hs), 8'(hh), 8'(lv), 8'(ls), 8'(lh)};
    endfunction

    function automatic t_box default_box(input logic [CFG_INDEX_BITS-1:0] idx);
        case (idx)
            REG_BLUE_BOX:   return pack_box(85, 30, 20, 150, 255, 255);
            REG_YELLOW_BOX: return pack_box(8, 30, 20, 43, 255, 255);
            REG_GREEN_BOX:  return pack_box(44, 30, 20, 75, 255, 255);
            REG_WHITE_BOX:  return pack_box(0, 0, 221, 180, 30, 255);
            REG_GRAY_BOX:   return pack_box(0, 0, 150, 180, 43, 221);
            default:        return pack_box(0, 0, 0, 180, 10, 150);
        endcase
    endfunction

    function automatic t_box random_box();
        int lo [3];
        int hi [3];
        for (int c = 0; c < 3; c++) begin
            lo[c] = $urandom_range(0, 255);
            // at times any high end (box may be empty), else a random-width window
            if ($urandom_range(0, 7) == 0)
                hi[c] = $urandom_range(0, 255);
            else
                hi[c] = (lo[c] + $urandom_range(0, 120) > 255) ? 255
                                                               : lo[c] + $urandom_range(0, 120);
        end
        return pack_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    function automatic bit pixel_in_box(input t_box b, input pixel_t p);
        logic [3*CHAN_BITS-1:0] lo;
        logic [3*CHAN_BITS-1:0] hi;
        logic [3*CHAN_BITS-1:0] ch;
        lo = b[3*CHAN_BITS-1:0];
        hi = b[6*CHAN_BITS-1:3*CHAN_BITS];
        ch = {p.val, p.sat, p.hue};
        for (int c = 0; c < 3; c++) begin
            if (ch[CHAN_BITS*c +: CHAN_BITS] < lo[CHAN_BITS*c +: CHAN_BITS] ||
                ch[CHAN_BITS*c +: CHAN_BITS] > hi[CHAN_BITS*c +: CHAN_BITS])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Pick a pixel inside the target box, often on its edges, sometimes one
    // step outside in a single channel; a noise target gives a random pixel.
    function automatic pixel_t pixel_from(input int tgt);
        pixel_t                 p;
        logic [3*CHAN_BITS-1:0] lo;
        logic [3*CHAN_BITS-1:0] hi;
        logic [3*CHAN_BITS-1:0] ch;
        int                     nudge;
        ch = 24'($urandom);
        if (tgt < NUM_CLASSES) begin
            lo = box_cfg[tgt][3*CHAN_BITS-1:0];
            hi = box_cfg[tgt][6*CHAN_BITS-1:3*CHAN_BITS];
            nudge = $urandom_range(0, 11);
            for (int c = 0; c < 3; c++) begin
                if (lo[CHAN_BITS*c +: CHAN_BITS] <= hi[CHAN_BITS*c +: CHAN_BITS]) begin
                    case ($urandom_range(0, 5))
                        0: ch[CHAN_BITS*c +: CHAN_BITS] = lo[CHAN_BITS*c +: CHAN_BITS];
                        1: ch[CHAN_BITS*c +: CHAN_BITS] = hi[CHAN_BITS*c +: CHAN_BITS];
                        default: ch[CHAN_BITS*c +: CHAN_BITS] =
                            CHAN_BITS'($urandom_range(hi[CHAN_BITS*c +: CHAN_BITS],
                                                      lo[CHAN_BITS*c +: CHAN_BITS]));
                    endcase
                    if (nudge == c)
                        ch[CHAN_BITS*c +: CHAN_BITS] = $urandom_range(0, 1) ?
                            lo[CHAN_BITS*c +: CHAN_BITS] - 1'b1 :
                            hi[CHAN_BITS*c +: CHAN_BITS] + 1'b1;
                end
            end
        end
        p.hue  = ch[CHAN_BITS-1:0];
        p.sat  = ch[2*CHAN_BITS-1:CHAN_BITS];
        p.val  = ch[3*CHAN_BITS-1:2*CHAN_BITS];
        p.last = 1'b0;
        return p;
    endfunction

    // Histogram predictor: bin one accepted pixel, decide on the last one.
    task automatic absorb_pixel(input pixel_t p);
        bit            placed;
        int            win;
        int            chrom;
        longint        classed;
        t_color        col;
        plate_result_t res;
        placed = 1'b0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (!placed && pixel_in_box(box_cfg[k], p)) begin
                placed = 1'b1;
                if (class_cnt[k] == COUNT_MAX)
                    sat_seen = 1'b1;
                else
                    class_cnt[k] = class_cnt[k] + 1'b1;
            end
        end
        if (pixel_cnt == COUNT_MAX)
            sat_seen = 1'b1;
        else
            pixel_cnt = pixel_cnt + 1'b1;
        if ({1'b0, vsum} + p.val > {1'b0, SUM_MAX}) begin
            vsum = SUM_MAX;
            sat_seen = 1'b1;
        end else begin
            vsum = vsum + p.val;
        end
        if (!p.last)
            return;

        win = 0;
        for (int k = 1; k < NUM_CLASSES; k++)
            if (class_cnt[k] > class_cnt[win])
                win = k;
        col = t_color'(win);
        if (win >= CLS_WHITE) begin
            // neutral winner: a strong enough chromatic class takes over
            chrom = 0;
            for (int k = 1; k < NUM_CHROMA; k++)
                if (class_cnt[k] > class_cnt[chrom])
                    chrom = k;
            classed = 0;
            for (int k = 0; k < NUM_CLASSES; k++)
                classed += class_cnt[k];
            if (class_cnt[chrom] >= classed / NUM_CLASSES)
                col = t_color'(chrom);
            else if (win == CLS_WHITE)
                col = COLOR_WHITE;
            else if (win == CLS_BLACK)
                col = COLOR_BLACK;
            else
                col = (longint'(vsum) > longint'(GRAY_SPLIT_V) * pixel_cnt) ? COLOR_WHITE
                                                                             : COLOR_BLACK;
        end
        res.color = col;
        res.sat   = sat_seen;
        plate_expect_q.insert(plate_expect_q.size(), res);
        for (int k = 0; k < NUM_CLASSES; k++)
            class_cnt[k] = '0;
        pixel_cnt = '0;
        vsum = '0;
        sat_seen = 1'b0;
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch on %s at result %0d: expected %0d, got %0d",
                     what, results_seen, want_v, got_v);
    endtask

    task automatic push_pixel(input int h, input int s, input int v, input bit last);
        pixel_t p;
        p.hue  = 8'(h);
        p.sat  = 8'(s);
        p.val  = 8'(v);
        p.last = last;
        pixel_q.insert(pixel_q.size(), p);
        if (last)
            images_queued++;
    endtask

    task automatic queue_image(input int len, input mix_e mix);
        int     tgt;
        int     r;
        pixel_t p;
        for (int i = 0; i < len; i++) begin
            case (mix)
                MIX_ANY: tgt = $urandom_range(0, TGT_NOISE);
                MIX_NEUTRAL: tgt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, NUM_CHROMA - 1)
                                                               : $urandom_range(CLS_WHITE,
                                                                                CLS_BLACK);
                default: begin
                    // gray against dim strays, chromatic share near one sixth
                    r = $urandom_range(0, 9);
                    tgt = (r < 5) ? CLS_GRAY : (r < 9) ? TGT_NOISE
                                                       : $urandom_range(0, NUM_CHROMA - 1);
                end
            endcase
            p = pixel_from(tgt);
            if (mix == MIX_GRAY && tgt == TGT_NOISE)
                p.val = 8'($urandom_range(0, 100));
            p.last = (i == len - 1);
            pixel_q.insert(pixel_q.size(), p);
        end
        images_queued++;
    endtask

    task automatic queue_images(input int budget, input int max_len);
        int left;
        int len;
        left = budget;
        while (left > 0) begin
            len = (max_len > 8 && $urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                              : $urandom_range(1, max_len);
            if (len > left)
                len = left;
            queue_image(len, mix_e'($urandom_range(0, 2)));
            left -= len;
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input t_box data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(negedge i_clk);
        while (!cfg_acc);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every pixel is taken and every color is back, then let the
    // pipeline settle before the boxes change.
    task automatic drain();
        while (pixel_q.size() != 0 || i_in_valid || plate_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // pixel driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || px_acc) begin
            if (gap_left > 0 || pixel_q.size() == 0) begin
                i_in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end else begin
                next_px = pixel_q.pop_front();
                i_in_valid   <= 1'b1;
                i_hue        <= next_px.hue;
                i_saturation <= next_px.sat;
                i_brightness <= next_px.val;
                i_last_pixel <= next_px.last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // color receiver: rotating stall pattern plus one long hold-off
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (holdoff_left > 0) begin
            i_out_ready  <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_arm && !holdoff_done) begin
            i_out_ready  <= 1'b0;
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
        end else begin
            case ((rx_cycle / 48) % 4)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= (rx_cycle % 4 == 0);
                default: i_out_ready <= (rx_cycle % 3 != 0);
            endcase
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        px_acc  <= i_rst_n && i_in_valid && o_in_ready;
        cfg_acc <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                if (i_cfg_index <= CFG_LAST_INDEX)
                    box_cfg[i_cfg_index] = i_cfg_data;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                color_tally[o_plate_color]++;
                if (plate_expect_q.size() == 0) begin
                    note_mismatch("unexpected color item", 0, 32'(o_plate_color));
                end else begin
                    want = plate_expect_q.pop_front();
                    if (o_plate_color !== want.color)
                        note_mismatch("plate_color", 32'(want.color), 32'(o_plate_color));
                    if (o_count_saturated !== want.sat)
                        note_mismatch("count_saturated", 32'(want.sat),
                                      32'(o_count_saturated));
                end
            end
            if (i_in_valid && o_in_ready) begin
                pixels_fed++;
                if (i_last_pixel)
                    images_done++;
                absorb_pixel('{hue: i_hue, sat: i_saturation, val: i_brightness,
                               last: i_last_pixel});
            end
            if (i_in_valid && !o_in_ready)
                in_held++;

            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d colors outstanding",
                         idle_cycles, plate_expect_q.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
            box_cfg[k]   = default_box(CFG_INDEX_BITS'(k));
            class_cnt[k] = '0;
        end
        for (int k = 0; k < 8; k++)
            color_tally[k] = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default boxes: directed corners first
        settings_run++;
        push_pixel(255, 255, 255, 1'b1);      // no box hit, empty tie goes to blue
        push_pixel(0, 0, 0, 1'b1);            // lone black, chromatic floor is zero
        repeat (5) push_pixel(0, 0, 255, 1'b0);
        push_pixel(60, 255, 255, 1'b1);       // green just makes a sixth of the image
        repeat (6) push_pixel(180, 43, 150, 1'b0);
        push_pixel(200, 0, 124, 1'b0);
        push_pixel(255, 0, 0, 1'b1);          // gray with V sum exactly 128 per pixel
        repeat (6) push_pixel(180, 30, 221, 1'b0);
        push_pixel(180, 30, 221, 1'b1);       // plain white
        push_pixel(8, 30, 20, 1'b1);          // yellow on its low corner
        queue_images(120, 14);
        drain();

        // random boxes, plus writes past the register list that must be dropped
        settings_run++;
        for (int r = REG_BLUE_BOX; r <= REG_BLACK_BOX; r++)
            write_reg(CFG_INDEX_BITS'(r), random_box());
        write_reg(REG_PAST_END, random_box());
        write_reg(REG_TOP_INDEX, '1);
        queue_images(120, 14);
        drain();

        // extreme boxes: single-point, full range and random
        settings_run++;
        write_reg(REG_BLUE_BOX, '0);
        write_reg(REG_YELLOW_BOX, '1);
        write_reg(REG_GREEN_BOX, pack_box(0, 0, 0, 255, 255, 255));
        write_reg(REG_WHITE_BOX, random_box());
        write_reg(REG_GRAY_BOX, random_box());
        write_reg(REG_BLACK_BOX, pack_box(0, 0, 0, 255, 255, 255));
        queue_images(80, 14);
        drain();

        // back to the default boxes; hold the output while short images pile up
        settings_run++;
        for (int r = REG_BLUE_BOX; r <= REG_BLACK_BOX; r++)
            write_reg(CFG_INDEX_BITS'(r), default_box(CFG_INDEX_BITS'(r)));
        holdoff_arm = 1'b1;
        queue_images(40, 3);
        queue_images(140, 14);
        while (images_queued < MIN_IMAGES)
            queue_image($urandom_range(1, 14), mix_e'($urandom_range(0, 2)));
        drain();

        $display("Covered %0d pixels in %0d images under %0d box settings, %0d config writes,",
                 pixels_fed, images_done, settings_run, cfg_writes);
        $display("input held %0d cycles; colors blue %0d yellow %0d green %0d white %0d black %0d",
                 in_held, color_tally[0], color_tally[1], color_tally[2], color_tally[3],
                 color_tally[4]);
        if (err_count == 0 && plate_expect_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- plate_color_histogram_classifier_top.f -----
rtl/core/pchc_pkg.sv
rtl/core/pchc_classify.sv
rtl/core/pchc_accum.sv
rtl/core/pchc_decide.sv
rtl/core/plate_color_histogram_classifier_top.sv
dv/tb.sv
